FILE: hdl/fqr_pkg.sv
// Package for the FIFO queue with remove-by-id: sizes, codes, controller-datapath structs.
// No dependencies; imported by fqr_ctrl, fqr_dp and fifo_queue_remove_by_id_top.
`timescale 1ns / 1ps

package fqr_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_W        = 16;
	localparam int OCC_W       = 5;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W       = CNT_W + 1;

	typedef enum logic [1:0] {
		MD_ENQ    = 2'd0,
		MD_DEQ    = 2'd1,
		MD_PEEK   = 2'd2,
		MD_REMOVE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		RS_ZERO,
		RS_READ,
		RS_ID
	} res_sel_t;

	typedef struct packed {
		logic     ld;
		logic     wr_tail;
		logic     rd_head;
		logic     pop;
		logic     rd_scan;
		logic     scan_first;
		logic     shift_wr;
		logic     drop;
		logic     fin;
		status_t  st;
		res_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic match;
		logic last;
		logic out_busy;
	} dp_sts_t;

	// circular slot of base + off, off never above the depth
	function automatic logic [IDX_W-1:0] slot_add(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(off);
		if (sum >= SUM_W'(QUEUE_DEPTH)) begin
			sum = sum - SUM_W'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: hdl/fqr_ctrl.sv
// Controller state machine for the FIFO queue with remove-by-id.
// Depends on fqr_pkg; drives fqr_dp through dp_cmd_t, reads dp_sts_t.
`timescale 1ns / 1ps

module fqr_ctrl import fqr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] mode,
	input  dp_sts_t    sts,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENQ,
		S_HEAD,
		S_REM,
		S_SCAN,
		S_SHIFT,
		S_FIN
	} state_t;

	state_t   state_q, state_d;
	mode_t    mode_q, mode_d;
	status_t  st_q, st_d;
	res_sel_t sel_q, sel_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		mode_d   = mode_q;
		st_d     = st_q;
		sel_d    = sel_q;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.ld = 1'b1;
					mode_d = mode_t'(mode);
					case (mode_t'(mode))
						MD_ENQ:           state_d = S_ENQ;
						MD_DEQ, MD_PEEK:  state_d = S_HEAD;
						MD_REMOVE:        state_d = S_REM;
						default:          state_d = S_IDLE;
					endcase
				end
			end
			S_ENQ: begin
				sel_d = RS_ZERO;
				if (sts.full) begin
					st_d = ST_FULL;
				end else begin
					cmd.wr_tail = 1'b1;
					st_d        = ST_OK;
				end
				state_d = S_FIN;
			end
			S_HEAD: begin
				if (sts.empty) begin
					st_d  = ST_EMPTY;
					sel_d = RS_ZERO;
				end else begin
					cmd.rd_head = 1'b1;
					cmd.pop     = (mode_q == MD_DEQ);
					st_d        = ST_OK;
					sel_d       = RS_READ;
				end
				state_d = S_FIN;
			end
			S_REM: begin
				if (sts.empty) begin
					st_d    = ST_EMPTY;
					sel_d   = RS_ZERO;
					state_d = S_FIN;
				end else begin
					cmd.rd_scan    = 1'b1;
					cmd.scan_first = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_scan = 1'b1;
				if (sts.match) begin
					if (sts.last) begin
						cmd.drop = 1'b1;
						st_d     = ST_OK;
						sel_d    = RS_ID;
						state_d  = S_FIN;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (sts.last) begin
					st_d    = ST_NOT_FOUND;
					sel_d   = RS_ZERO;
					state_d = S_FIN;
				end
			end
			S_SHIFT: begin
				cmd.rd_scan  = 1'b1;
				cmd.shift_wr = 1'b1;
				if (sts.last) begin
					cmd.drop = 1'b1;
					st_d     = ST_OK;
					sel_d    = RS_ID;
					state_d  = S_FIN;
				end
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.st  = st_q;
		cmd.sel = sel_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= MD_ENQ;
			st_q    <= ST_OK;
			sel_q   <= RS_ZERO;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			st_q    <= st_d;
			sel_q   <= sel_d;
		end
	end

endmodule

FILE: hdl/fqr_dp.sv
// Datapath for the FIFO queue with remove-by-id: entry memory, head/count, scan, result register.
// Depends on fqr_pkg; commanded by fqr_ctrl.
`timescale 1ns / 1ps

module fqr_dp import fqr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [ID_W-1:0]   item_id,
	input  dp_cmd_t           cmd,
	output dp_sts_t           sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ID_W-1:0]   result_id,
	output logic [1:0]        status,
	output logic [OCC_W-1:0]  occupancy
);

	logic [ID_W-1:0]  mem [QUEUE_DEPTH];
	logic [ID_W-1:0]  id_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] off_s1;
	logic [ID_W-1:0]  rd_data_s1;

	logic             wr_en, rd_en;
	logic [IDX_W-1:0] wr_addr, rd_addr;
	logic [ID_W-1:0]  wr_data;
	logic [CNT_W-1:0] rd_off;

	logic             out_valid_q;
	logic [ID_W-1:0]  result_id_q;
	status_t          status_q;
	logic [OCC_W-1:0] occ_q;

	always_comb begin
		wr_en   = cmd.wr_tail | cmd.shift_wr;
		wr_addr = cmd.wr_tail ? slot_add(head_q, cnt_q) : slot_add(head_q, off_s1 - 1'b1);
		wr_data = cmd.wr_tail ? id_q : rd_data_s1;
		rd_en   = cmd.rd_head | cmd.rd_scan;
		rd_off  = (cmd.rd_head | cmd.scan_first) ? '0 : scan_q;
		rd_addr = slot_add(head_q, rd_off);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld) begin
			id_q <= item_id;
		end
		if (cmd.rd_scan) begin
			scan_q <= cmd.scan_first ? CNT_W'(1) : CNT_W'(scan_q + 1'b1);
			off_s1 <= rd_off;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.wr_tail) begin
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end
			if (cmd.pop) begin
				head_q <= slot_add(head_q, CNT_W'(1));
				cnt_q  <= CNT_W'(cnt_q - 1'b1);
			end
			if (cmd.drop) begin
				cnt_q <= CNT_W'(cnt_q - 1'b1);
			end
		end
	end

	always_comb begin
		sts.empty    = (cnt_q == '0);
		sts.full     = (cnt_q == CNT_W'(QUEUE_DEPTH));
		sts.match    = (rd_data_s1 == id_q);
		sts.last     = (off_s1 == CNT_W'(cnt_q - 1'b1));
		sts.out_busy = out_valid_q & out_stall;
	end

	// result register: parts the work from the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			case (cmd.sel)
				RS_READ: result_id_q <= rd_data_s1;
				RS_ID:   result_id_q <= id_q;
				default: result_id_q <= '0;
			endcase
			status_q <= cmd.st;
			occ_q    <= OCC_W'(cnt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign result_id = result_id_q;
	assign status    = status_q;
	assign occupancy = occ_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !sts.out_busy)
		else $error("result register overwritten while held");

	a_enq_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_tail |-> !sts.full)
		else $error("enqueue into full queue");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pop || cmd.drop) |=> cnt_q == CNT_W'($past(cnt_q) - 1'b1))
		else $error("count not decremented on removal");

endmodule

FILE: hdl/fifo_queue_remove_by_id_top.sv
// Top level of the FIFO queue with remove-by-id; joins fqr_ctrl and fqr_dp.
// Depends on fqr_pkg, fqr_ctrl, fqr_dp.
//
//  channel | handshake          | payload
//  in      | in_valid/in_stall  | mode[1:0], item_id[15:0]
//  out     | out_valid/out_stall| result_id[15:0], status[1:0], occupancy[4:0]
//
// Enqueue, dequeue, peek: from idle the request passes the enqueue or head state, then the
// finish state, which loads the result; the next request is taken once back in idle.
// Remove: remove, scan, then shift if the match is not the tail, then finish; the
// single-read-port entry memory is walked one slot a cycle to find the match, then to
// close the gap. An empty queue gives the same timing as enqueue.
// in_stall is high from the taking edge until the result is loaded, and longer while a
// previous result is still held under out_stall.
// arst_n clears head, count and the controller; the entry memory is not cleared.
`timescale 1ns / 1ps

module fifo_queue_remove_by_id_top import fqr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        mode,
	input  logic [ID_W-1:0]   item_id,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [ID_W-1:0]   result_id,
	output logic [1:0]        status,
	output logic [OCC_W-1:0]  occupancy
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	fqr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	fqr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_id   (item_id),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result_id (result_id),
		.status    (status),
		.occupancy (occupancy)
	);

endmodule

FILE: dv/fqr_queue_sb_pkg.sv
// Scoreboard for the FIFO queue with remove-by-id: predicts each result and checks the DUT output.
// Depends on fqr_pkg; imported by tb_top.
`timescale 1ns / 1ps

package fqr_queue_sb_pkg;
	import fqr_pkg::*;

	typedef struct {
		logic [ID_W-1:0]  id;
		status_t          st;
		logic [OCC_W-1:0] occ;
	} queue_result_t;

	class queue_scoreboard;
		logic [ID_W-1:0] held[$];	// ids held by the queue, head first
		queue_result_t   awaited[$];
		int              errors;

		function new();
			errors = 0;
		endfunction

		function void note_request(mode_t m, logic [ID_W-1:0] id);
			queue_result_t r;
			int            pos;
			r.id = '0;
			r.st = ST_OK;
			pos  = -1;
			case (m)
			MD_ENQ: begin
				if (held.size() >= QUEUE_DEPTH) r.st = ST_FULL;
				else held.push_back(id);
			end
			MD_DEQ, MD_PEEK: begin
				if (held.size() == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.id = held[0];
					if (m == MD_DEQ) void'(held.pop_front());
				end
			end
			default: begin
				if (held.size() == 0) begin
					r.st = ST_EMPTY;
				end else begin
					// first match from the head only
					foreach (held[i]) if (pos < 0 && held[i] == id) pos = i;
					if (pos < 0) begin
						r.st = ST_NOT_FOUND;
					end else begin
						r.id = id;
						held.delete(pos);
					end
				end
			end
			endcase
			r.occ = OCC_W'(held.size());
			awaited.push_back(r);
		endfunction

		task report(string what, int got, int want);
			$display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
			errors++;
		endtask

		task check_result(logic [ID_W-1:0] id, logic [1:0] st, logic [OCC_W-1:0] occ);
			queue_result_t r;
			if (awaited.size() == 0) begin
				report("unexpected result, result_id", id, 0);
				return;
			end
			r = awaited.pop_front();
			if (id !== r.id) report("result_id", id, r.id);
			if (st !== r.st) report("status", st, r.st);
			if (occ !== r.occ) report("occupancy", occ, r.occ);
		endtask

		function int pending();
			return awaited.size();
		endfunction
	endclass

endpackage

FILE: dv/tb_top.sv
// Testbench top for fifo_queue_remove_by_id_top: directed and random requests under varied idling and output stalls.
// Depends on fqr_pkg, fqr_queue_sb_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
	import fqr_pkg::*;
	import fqr_queue_sb_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic [1:0]       mode;
	logic [ID_W-1:0]  item_id;
	logic             out_valid;
	logic             out_stall;
	logic [ID_W-1:0]  result_id;
	logic [1:0]       status;
	logic [OCC_W-1:0] occupancy;

	int              idle_pct;
	int              stall_pct;
	logic            hold_req;
	logic            hold_active;
	queue_scoreboard sb;

	fifo_queue_remove_by_id_top DUT (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(result_id, status, occupancy);
	end

	// long receiver hold-off so the queue backs up into the input
	initial begin
		hold_active = 1'b0;
		wait (hold_req);
		@(posedge clk);
		hold_active <= 1'b1;
		repeat (300) @(posedge clk);
		hold_active <= 1'b0;
	end

	task send(input mode_t m, input logic [ID_W-1:0] id);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		item_id  <= id;
		do @(posedge clk); while (in_stall);
		sb.note_request(m, id);
	endtask

	task send_random(input bit fill);
		int              r;
		mode_t           m;
		logic [ID_W-1:0] id;
		r = $urandom_range(0, 99);
		if (fill) m = (r < 50) ? MD_ENQ : (r < 65) ? MD_DEQ : (r < 75) ? MD_PEEK : MD_REMOVE;
		else m = (r < 20) ? MD_ENQ : (r < 55) ? MD_DEQ : (r < 65) ? MD_PEEK : MD_REMOVE;
		r = $urandom_range(0, 99);
		if (m == MD_REMOVE && sb.held.size() != 0 && r < 75)
			id = sb.held[$urandom_range(0, sb.held.size() - 1)];
		else if (r < 88)
			id = (r & 1) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
		else
			id = (r & 1) ? '1 : '0;
		send(m, id);
	endtask

	task wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = MD_ENQ;
		item_id   = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_req  = 1'b0;
		sb        = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue on every read-type request
		send(MD_DEQ, 16'h0000);
		send(MD_PEEK, 16'hFFFF);
		send(MD_REMOVE, 16'h0000);
		// duplicates, remove nearest head, not found
		send(MD_ENQ, 16'hFFFF);
		send(MD_ENQ, 16'h0000);
		send(MD_ENQ, 16'h0000);
		send(MD_REMOVE, 16'h0000);
		send(MD_PEEK, 16'h1234);
		send(MD_REMOVE, 16'h1234);
		send(MD_DEQ, 16'h0000);
		// fill to the brim, then overflow
		for (int i = 0; i < QUEUE_DEPTH; i++) send(MD_ENQ, ID_W'(16'h5A00 + i));
		send(MD_REMOVE, 16'h5A0E);
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = (phase == 1) ? 48 : (phase == 3) ? 32 : 0;
			stall_pct = (phase == 2) ? 48 : (phase == 3) ? 32 : 0;
			for (int k = 0; k < 250; k++) begin
				if (phase == 0 && k == 100) hold_req = 1'b1;
				send_random(((k / 40) % 2) == 0);
			end
			wait_drained();
		end

		repeat (40) @(posedge clk);
		if (sb.errors == 0) $display("All tests passed");
		else $display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: fifo_queue_remove_by_id_top.f
hdl/fqr_pkg.sv
hdl/fqr_ctrl.sv
hdl/fqr_dp.sv
hdl/fifo_queue_remove_by_id_top.sv
dv/fqr_queue_sb_pkg.sv
dv/tb_top.sv
